[rtl/redo_log_transaction_tracker_macros.svh]
// ----------------------------------------------------------------------------
// Redo log transaction tracker assertion macros
// Concurrent assertion wrappers; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef REDO_LOG_TRANSACTION_TRACKER_MACROS_SVH
`define REDO_LOG_TRANSACTION_TRACKER_MACROS_SVH

`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset
`define RLT_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("redo log tracker assertion failed");
// Property that must hold in the cycle after the trigger
`define RLT_ASSERT_NEXT(label, clk, rst_n, trig, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (trig) |=> (prop)) \
        else $error("redo log tracker assertion failed");
`else
`define RLT_ASSERT(label, clk, rst_n, prop)
`define RLT_ASSERT_NEXT(label, clk, rst_n, trig, prop)
`endif

`endif

[rtl/rlt_pkg.sv]
// ----------------------------------------------------------------------------
// Redo log transaction tracker package
// Shared item types, status and opcode codes, and cell control struct.
// ----------------------------------------------------------------------------
`default_nettype none

package rlt_pkg;

    // Width of one home block number
    localparam int BLOCK_W = 32;

    // Configuration register indexes
    localparam logic [1:0] CFG_DEVICE_ID = 2'd0;
    localparam logic [1:0] CFG_LOG_START = 2'd1;
    localparam logic [1:0] CFG_LOG_SIZE  = 2'd2;

    // Configuration reset values
    localparam logic [7:0]  DEVICE_ID_RESET = 8'd0;
    localparam logic [31:0] LOG_START_RESET = 32'd0;
    localparam logic [15:0] LOG_SIZE_RESET  = 16'd33;

    typedef enum logic [1:0] {
        OP_BEGIN = 2'd0,
        OP_END   = 2'd1,
        OP_WRITE = 2'd2,
        OP_DONE  = 2'd3
    } t_opcode;

    typedef enum logic [3:0] {
        ST_GRANTED         = 4'd0,
        ST_WAIT            = 4'd1,
        ST_APPENDED        = 4'd2,
        ST_ABSORBED        = 4'd3,
        ST_END_PENDING     = 4'd4,
        ST_END_EMPTY       = 4'd5,
        ST_COMMIT_ENTRY    = 4'd6,
        ST_COMMIT_FINISHED = 4'd7,
        ST_ERR_DEVICE      = 4'd8,
        ST_ERR_TOO_BIG     = 4'd9,
        ST_ERR_NO_TXN      = 4'd10,
        ST_ERR_END_COMMIT  = 4'd11,
        ST_ERR_END_IDLE    = 4'd12,
        ST_ERR_DONE_IDLE   = 4'd13
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_SEARCH = 2'd1,
        S_COMMIT = 2'd2
    } t_state;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  device;
        logic [31:0] block_number;
    } t_item;

    typedef struct packed {
        logic [3:0]  status;
        logic [31:0] home_block;
        logic [31:0] log_block;
        logic [5:0]  entry_index;
        logic        last;
    } t_result;

    // Per-cell control: rotate the ring, or load the broadcast key
    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctrl;

endpackage

`default_nettype wire

[rtl/rlt_cell.sv]
// ----------------------------------------------------------------------------
// Redo log table cell
// Holds one logged block number; rotates toward its neighbor or loads a key.
// ----------------------------------------------------------------------------
`default_nettype none

module rlt_cell (
    input  wire logic                       i_clk,
    input  wire rlt_pkg::t_cell_ctrl        i_ctrl,
    input  wire logic [rlt_pkg::BLOCK_W-1:0] i_load_data,
    input  wire logic [rlt_pkg::BLOCK_W-1:0] i_next_data,
    output logic      [rlt_pkg::BLOCK_W-1:0] o_data
);

    logic [rlt_pkg::BLOCK_W-1:0] r_data;
    logic [rlt_pkg::BLOCK_W-1:0] n_data;

    // Load wins over rotation
    always_comb begin
        priority if (i_ctrl.load) begin
            n_data = i_load_data;
        end else if (i_ctrl.shift) begin
            n_data = i_next_data;
        end else begin
            n_data = r_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

[rtl/redo_log_transaction_tracker.sv]
// ----------------------------------------------------------------------------
// Redo log transaction tracker
// Tracks the write set of a redo-log transaction with write absorption.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on i_item when start is high and busy is low. Each result
//   is shown for one cycle on o_result, marked by o_result_valid; the
//   receiver cannot stall, so results are simply presented and dropped.
//   The user must write configuration registers over i_cfg_* only while the
//   block idles; o_cfg_ready stays high and the block does not enforce this.
// Throughput:
//   Begin, end without commit, commit done and rejected writes return one
//   result in the cycle after acceptance; a new item may follow every cycle.
//   An accepted write rotates the ring of CAP cells once, with CAP the smaller
//   of LOG_ENTRIES and 32; busy is high during the search and the result is
//   registered when the rotation ends. A commit also rotates the ring once:
//   entries come out one per cycle, and busy stays high until the rotation ends.
// Reset:
//   Clears operation count, commit flag, entry count and the configuration.
//   Table contents stay undefined; only entries below the count are read.
// ----------------------------------------------------------------------------
`default_nettype none

`include "redo_log_transaction_tracker_macros.svh"

module redo_log_transaction_tracker #(
    parameter int LOG_ENTRIES = 32,
    parameter int OP_BLOCKS   = 10
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    // Command channel
    input  wire logic             start,
    output logic                  busy,
    input  wire rlt_pkg::t_item   i_item,
    // Result channel
    output logic                  o_result_valid,
    output rlt_pkg::t_result      o_result,
    // Configuration channel
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [1:0]       i_cfg_index,
    input  wire logic [31:0]      i_cfg_data
);

    localparam int CAP = (LOG_ENTRIES < 32) ? LOG_ENTRIES : 32;
    localparam int IW  = $clog2(CAP);
    localparam int CW  = $clog2(CAP + 1);
    localparam logic [IW-1:0] LAST_STEP = IW'(CAP - 1);

    // Configuration registers
    logic [7:0]  r_device_id;
    logic [31:0] r_log_start;
    logic [15:0] r_log_size;

    // Control state
    rlt_pkg::t_state r_state, n_state;
    logic [5:0]    r_ops, n_ops;
    logic          r_busy, n_busy;
    logic [CW-1:0] r_count, n_count;
    logic [IW-1:0] r_step, n_step;
    logic          r_hit, n_hit;
    logic [IW-1:0] r_hit_idx, n_hit_idx;
    logic [31:0]   r_key, n_key;
    logic          r_out_valid, n_out_valid;
    rlt_pkg::t_result r_out, n_out;

    // Cell chain
    logic [rlt_pkg::BLOCK_W-1:0] w_cell_data [CAP];
    logic [rlt_pkg::BLOCK_W-1:0] w_head;
    logic          w_shift;
    logic          w_load_fire;

    // Decode
    logic          w_accept;
    rlt_pkg::t_opcode w_op;
    logic          w_dev_ok;
    logic          w_full;
    logic [12:0]   w_need;
    logic          w_begin_wait;
    logic          w_write_go;
    logic          w_commit_go;
    logic          w_match;
    logic          w_hit_final;
    logic [IW-1:0] w_hit_idx_final;
    logic          w_slot_en;
    logic [IW-1:0] w_slot_sel;

    assign w_accept = start && !busy;
    assign w_op     = rlt_pkg::t_opcode'(i_item.opcode);
    assign w_head   = w_cell_data[0];

    // Admission checks
    assign w_dev_ok = (i_item.device == r_device_id);
    assign w_full   = (r_count >= CW'(CAP))
                   || ((17'(r_count) + 17'd1) >= 17'(r_log_size));
    assign w_need   = 13'(r_count) + 13'(7'(r_ops) + 7'd1) * 13'(OP_BLOCKS);
    assign w_begin_wait = r_busy || (r_ops == 6'd63) || (w_need > 13'(CAP));

    assign w_write_go  = w_accept && (w_op == rlt_pkg::OP_WRITE) && w_dev_ok
                      && !w_full && (r_ops != 6'd0);
    assign w_commit_go = w_accept && (w_op == rlt_pkg::OP_END) && !r_busy
                      && (r_ops == 6'd1) && (r_count != '0);

    // Compare the head cell against the key during the search rotation
    assign w_match         = (CW'(r_step) < r_count) && (w_head == r_key);
    assign w_hit_final     = r_hit || w_match;
    assign w_hit_idx_final = r_hit ? r_hit_idx : r_step;

    // Cell row: every cell rotates toward cell 0, the tail wraps
    for (genvar gi = 0; gi < CAP; gi++) begin : g_cell
        localparam int NXT = (gi + 1) % CAP;
        rlt_pkg::t_cell_ctrl w_ctrl;

        assign w_ctrl.shift = w_shift;
        assign w_ctrl.load  = w_load_fire && (r_count == CW'(gi));

        rlt_cell u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (w_ctrl),
            .i_load_data (r_key),
            .i_next_data (w_cell_data[NXT]),
            .o_data      (w_cell_data[gi])
        );
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rlt_pkg::S_IDLE: begin
                if (w_write_go) begin
                    n_state = rlt_pkg::S_SEARCH;
                end else if (w_commit_go) begin
                    n_state = rlt_pkg::S_COMMIT;
                end
            end
            rlt_pkg::S_SEARCH, rlt_pkg::S_COMMIT: begin
                if (r_step == LAST_STEP) begin
                    n_state = rlt_pkg::S_IDLE;
                end
            end
            default: n_state = rlt_pkg::S_IDLE;
        endcase
    end

    // Datapath and results
    always_comb begin
        n_ops       = r_ops;
        n_busy      = r_busy;
        n_count     = r_count;
        n_step      = r_step;
        n_hit       = r_hit;
        n_hit_idx   = r_hit_idx;
        n_key       = r_key;
        n_out_valid = 1'b0;
        n_out       = '0;
        n_out.last  = 1'b1;
        w_shift     = 1'b0;
        w_load_fire = 1'b0;
        w_slot_en   = 1'b0;
        w_slot_sel  = '0;

        unique case (r_state)
            rlt_pkg::S_IDLE: begin
                if (w_accept) begin
                    unique case (w_op)
                        rlt_pkg::OP_BEGIN: begin
                            n_out_valid = 1'b1;
                            if (w_begin_wait) begin
                                n_out.status = rlt_pkg::ST_WAIT;
                            end else begin
                                n_ops        = r_ops + 6'd1;
                                n_out.status = rlt_pkg::ST_GRANTED;
                            end
                        end
                        rlt_pkg::OP_END: begin
                            priority if (r_busy) begin
                                n_out_valid  = 1'b1;
                                n_out.status = rlt_pkg::ST_ERR_END_COMMIT;
                            end else if (r_ops == 6'd0) begin
                                n_out_valid  = 1'b1;
                                n_out.status = rlt_pkg::ST_ERR_END_IDLE;
                            end else if (r_ops != 6'd1) begin
                                n_ops        = r_ops - 6'd1;
                                n_out_valid  = 1'b1;
                                n_out.status = rlt_pkg::ST_END_PENDING;
                            end else if (r_count == '0) begin
                                n_ops        = 6'd0;
                                n_out_valid  = 1'b1;
                                n_out.status = rlt_pkg::ST_END_EMPTY;
                            end else begin
                                // Last end with entries: start the commit sweep
                                n_ops  = 6'd0;
                                n_busy = 1'b1;
                                n_step = '0;
                            end
                        end
                        rlt_pkg::OP_WRITE: begin
                            priority if (!w_dev_ok) begin
                                n_out_valid  = 1'b1;
                                n_out.status = rlt_pkg::ST_ERR_DEVICE;
                            end else if (w_full) begin
                                n_out_valid  = 1'b1;
                                n_out.status = rlt_pkg::ST_ERR_TOO_BIG;
                            end else if (r_ops == 6'd0) begin
                                n_out_valid  = 1'b1;
                                n_out.status = rlt_pkg::ST_ERR_NO_TXN;
                            end else begin
                                // Start the lookup rotation
                                n_key     = i_item.block_number;
                                n_step    = '0;
                                n_hit     = 1'b0;
                                n_hit_idx = '0;
                            end
                        end
                        rlt_pkg::OP_DONE: begin
                            n_out_valid = 1'b1;
                            if (!r_busy) begin
                                n_out.status = rlt_pkg::ST_ERR_DONE_IDLE;
                            end else begin
                                n_busy       = 1'b0;
                                n_count      = '0;
                                n_out.status = rlt_pkg::ST_COMMIT_FINISHED;
                            end
                        end
                    endcase
                end
            end
            rlt_pkg::S_SEARCH: begin
                w_shift = 1'b1;
                n_step  = r_step + IW'(1);
                if (w_match && !r_hit) begin
                    n_hit     = 1'b1;
                    n_hit_idx = r_step;
                end
                if (r_step == LAST_STEP) begin
                    // Ring is back in place after this shift; report the lookup
                    n_out_valid      = 1'b1;
                    n_out.home_block = r_key;
                    w_slot_en        = 1'b1;
                    if (w_hit_final) begin
                        n_out.status = rlt_pkg::ST_ABSORBED;
                        w_slot_sel   = w_hit_idx_final;
                    end else begin
                        n_out.status = rlt_pkg::ST_APPENDED;
                        w_slot_sel   = IW'(r_count);
                        w_load_fire  = 1'b1;
                        n_count      = r_count + CW'(1);
                    end
                    n_out.entry_index = 6'(w_slot_sel);
                end
            end
            rlt_pkg::S_COMMIT: begin
                w_shift = 1'b1;
                n_step  = r_step + IW'(1);
                if (CW'(r_step) < r_count) begin
                    n_out_valid       = 1'b1;
                    n_out.status      = rlt_pkg::ST_COMMIT_ENTRY;
                    n_out.home_block  = w_head;
                    n_out.entry_index = 6'(r_step);
                    n_out.last        = ((CW'(r_step) + CW'(1)) == r_count);
                    w_slot_en         = 1'b1;
                    w_slot_sel        = r_step;
                end
            end
            default: begin
                n_step = '0;
            end
        endcase

        // Log slot: entry index plus one past the header
        if (w_slot_en) begin
            n_out.log_block = r_log_start + 32'(w_slot_sel) + 32'd1;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rlt_pkg::S_IDLE;
            r_ops       <= '0;
            r_busy      <= 1'b0;
            r_count     <= '0;
            r_step      <= '0;
            r_hit       <= 1'b0;
            r_hit_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ops       <= n_ops;
            r_busy      <= n_busy;
            r_count     <= n_count;
            r_step      <= n_step;
            r_hit       <= n_hit;
            r_hit_idx   <= n_hit_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_out <= n_out;
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_id <= rlt_pkg::DEVICE_ID_RESET;
            r_log_start <= rlt_pkg::LOG_START_RESET;
            r_log_size  <= rlt_pkg::LOG_SIZE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                rlt_pkg::CFG_DEVICE_ID: r_device_id <= i_cfg_data[7:0];
                rlt_pkg::CFG_LOG_START: r_log_start <= i_cfg_data;
                rlt_pkg::CFG_LOG_SIZE:  r_log_size  <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign busy           = (r_state != rlt_pkg::S_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

    // Checks
    `RLT_ASSERT(a_commit_no_ops, i_clk, i_rst_n, r_busy |-> (r_ops == 6'd0))
    `RLT_ASSERT(a_commit_flag, i_clk, i_rst_n, (r_state == rlt_pkg::S_COMMIT) |-> r_busy)
    `RLT_ASSERT_NEXT(a_search_result, i_clk, i_rst_n, (r_state == rlt_pkg::S_SEARCH) && (r_step == LAST_STEP), o_result_valid && o_result.last)
    `RLT_ASSERT(a_append_count, i_clk, i_rst_n, (o_result_valid && (o_result.status == rlt_pkg::ST_APPENDED)) |-> (7'(r_count) == (7'(o_result.entry_index) + 7'd1)))

endmodule

`default_nettype wire
